FILE: hdl/mqsb_pkg.sv
// ----------------------------------------------------------------------------
// mqsb_pkg
// Shared types and constants for the multi-queue shared buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package mqsb_pkg;

    // Request field widths
    localparam int DATA_W = 32;
    localparam int QID_W  = 2;

    // Value returned by a dequeue from an empty queue
    localparam logic [DATA_W-1:0] EMPTY_VALUE = 32'h7FFF_FFFF;

    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    // One request as held in the input register
    typedef struct packed {
        op_t                      op;
        logic [QID_W-1:0]         qid;
        logic signed [DATA_W-1:0] item;
    } req_t;

endpackage

`default_nettype wire

FILE: hdl/multi_queue_shared_buffer.sv
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer
// Several FIFO queues sharing one slot store through linked slots; freed
// slots are kept on a linked recycle stack, untouched slots come from a
// fill counter.
// ----------------------------------------------------------------------------
// Each request is held in the input register, then its result in the result register.
// Throughput: one request per cycle while the output is not stalled; the link RAM read
//   of one request feeds the pointer bypass of the next, so back-to-back requests do not wait.
// Output stall holds the result register and, once the input register is
//   also occupied, stalls the input channel.
// Reset: all queues empty, every slot free; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_queue_shared_buffer #(
    parameter int NUM_QUEUES = 4,
    parameter int NUM_SLOTS  = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // request channel
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic                                  opcode,
    input  wire logic [mqsb_pkg::QID_W-1:0]            queue_id,
    input  wire logic signed [mqsb_pkg::DATA_W-1:0]    item,
    // result channel
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic signed [mqsb_pkg::DATA_W-1:0]         data,
    output logic [1:0]                                 status,
    output logic                                       store_full
);

    localparam int SW = $clog2(NUM_SLOTS);
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

    // ------------------------------------------------------------------
    // Signals
    // ------------------------------------------------------------------
    logic               s1_valid_reg, s1_valid_next;
    mqsb_pkg::req_t     s1_req_reg;
    logic               s1_fire;
    logic               s2_free;
    logic               in_take;

    logic               s2_valid_reg, s2_valid_next;
    mqsb_pkg::status_t  s2_status_reg, s2_status_next;
    logic               s2_full_reg, s2_full_next;
    logic               s2_rdsel_reg, s2_rdsel_next;
    logic [mqsb_pkg::DATA_W-1:0] s2_data_reg, s2_data_next;

    logic [SW-1:0]      head_reg [NUM_QUEUES];
    logic [SW-1:0]      head_next [NUM_QUEUES];
    logic [SW-1:0]      head_eff [NUM_QUEUES];
    logic [SW-1:0]      tail_reg [NUM_QUEUES];
    logic [SW-1:0]      tail_next [NUM_QUEUES];
    logic [NUM_QUEUES-1:0] hok_reg, hok_next;

    logic [SW-1:0]      rhead_reg, rhead_next, rhead_eff;
    logic [CW-1:0]      rcnt_reg, rcnt_next;
    logic [CW-1:0]      fresh_reg, fresh_next;
    logic [CW-1:0]      free_cnt_reg, free_cnt_next;

    logic               pend_valid_reg, pend_valid_next;
    logic               pend_free_reg, pend_free_next;
    logic [QW-1:0]      pend_q_reg, pend_q_next;

    logic [QW-1:0]      q_idx;
    logic               q_ok;
    logic [SW-1:0]      enq_slot;
    logic [SW-1:0]      deq_slot;
    logic               deq_last;
    logic               q_has_items;

    logic               link_we, link_re;
    logic [SW-1:0]      link_waddr, link_wdata, link_raddr, link_rdata;
    logic               val_we, val_re;
    logic [SW-1:0]      val_waddr, val_raddr;
    logic [mqsb_pkg::DATA_W-1:0] val_wdata, val_rdata;

    // ------------------------------------------------------------------
    // Handshake and pipeline control
    // ------------------------------------------------------------------
    assign s2_free  = !s2_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && s2_free;
    assign in_stall = s1_valid_reg && !s2_free;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    assign s2_valid_next = s2_free ? s1_fire : s2_valid_reg;

    // ------------------------------------------------------------------
    // Pointer bypass: a pointer fetched from the link RAM last cycle
    // is taken straight from the RAM output
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int i = 0; i < NUM_QUEUES; i++)
        begin
            head_eff[i] = (pend_valid_reg && !pend_free_reg && pend_q_reg == QW'(i))
                          ? link_rdata : head_reg[i];
        end
    end

    assign rhead_eff = (pend_valid_reg && pend_free_reg) ? link_rdata : rhead_reg;

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    assign q_idx       = QW'(s1_req_reg.qid);
    assign q_ok        = int'(s1_req_reg.qid) < NUM_QUEUES;
    assign q_has_items = q_ok && hok_reg[q_idx];
    assign enq_slot    = (rcnt_reg != '0) ? rhead_eff : fresh_reg[SW-1:0];
    assign deq_slot    = head_eff[q_idx];
    assign deq_last    = (deq_slot == tail_reg[q_idx]);

    // ------------------------------------------------------------------
    // Queue and free-list update
    // ------------------------------------------------------------------
    always_comb
    begin
        head_next       = head_eff;
        tail_next       = tail_reg;
        hok_next        = hok_reg;
        rhead_next      = rhead_eff;
        rcnt_next       = rcnt_reg;
        fresh_next      = fresh_reg;
        free_cnt_next   = free_cnt_reg;
        pend_valid_next = 1'b0;
        pend_free_next  = 1'b0;
        pend_q_next     = q_idx;

        link_we    = 1'b0;
        link_waddr = tail_reg[q_idx];
        link_wdata = enq_slot;
        link_re    = 1'b0;
        link_raddr = rhead_eff;
        val_we     = 1'b0;
        val_waddr  = enq_slot;
        val_wdata  = $unsigned(s1_req_reg.item);
        val_re     = 1'b0;
        val_raddr  = deq_slot;

        s2_status_next = mqsb_pkg::ST_OK;
        s2_data_next   = '0;
        s2_rdsel_next  = 1'b0;

        if (s1_fire)
        begin
            unique case (s1_req_reg.op)
                mqsb_pkg::OP_ENQ:
                begin
                    if (!q_ok || free_cnt_reg == '0)
                    begin
                        s2_status_next = mqsb_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        // take a recycled slot first, else a never-used one
                        if (rcnt_reg != '0)
                        begin
                            rcnt_next       = rcnt_reg - CW'(1);
                            link_re         = 1'b1;
                            link_raddr      = rhead_eff;
                            pend_valid_next = 1'b1;
                            pend_free_next  = 1'b1;
                        end
                        else
                        begin
                            fresh_next = fresh_reg + CW'(1);
                        end
                        free_cnt_next = free_cnt_reg - CW'(1);

                        // append to the queue
                        if (!hok_reg[q_idx])
                        begin
                            head_next[q_idx] = enq_slot;
                            hok_next[q_idx]  = 1'b1;
                        end
                        else
                        begin
                            link_we    = 1'b1;
                            link_waddr = tail_reg[q_idx];
                            link_wdata = enq_slot;
                        end
                        tail_next[q_idx] = enq_slot;
                        val_we           = 1'b1;
                    end
                end

                mqsb_pkg::OP_DEQ:
                begin
                    if (!q_has_items)
                    begin
                        s2_status_next = mqsb_pkg::ST_UNDERFLOW;
                        s2_data_next   = mqsb_pkg::EMPTY_VALUE;
                    end
                    else
                    begin
                        // unlink the head; last item empties the queue
                        if (deq_last)
                        begin
                            hok_next[q_idx] = 1'b0;
                        end
                        else
                        begin
                            link_re         = 1'b1;
                            link_raddr      = deq_slot;
                            pend_valid_next = 1'b1;
                        end

                        // push the slot onto the recycle stack
                        link_we       = 1'b1;
                        link_waddr    = deq_slot;
                        link_wdata    = rhead_eff;
                        rhead_next    = deq_slot;
                        rcnt_next     = rcnt_reg + CW'(1);
                        free_cnt_next = free_cnt_reg + CW'(1);

                        val_re        = 1'b1;
                        s2_rdsel_next = 1'b1;
                    end
                end

                default:
                begin
                    s2_status_next = mqsb_pkg::ST_OK;
                end
            endcase
        end
    end

    assign s2_full_next = (free_cnt_next == '0);

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            hok_reg        <= '0;
            rcnt_reg       <= '0;
            fresh_reg      <= '0;
            free_cnt_reg   <= CW'(NUM_SLOTS);
            pend_valid_reg <= 1'b0;
            pend_free_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            s2_valid_reg   <= s2_valid_next;
            hok_reg        <= hok_next;
            rcnt_reg       <= rcnt_next;
            fresh_reg      <= fresh_next;
            free_cnt_reg   <= free_cnt_next;
            pend_valid_reg <= pend_valid_next;
            pend_free_reg  <= pend_free_next;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        head_reg   <= head_next;
        tail_reg   <= tail_next;
        rhead_reg  <= rhead_next;
        pend_q_reg <= pend_q_next;
        if (in_take)
        begin
            s1_req_reg.op   <= mqsb_pkg::op_t'(opcode);
            s1_req_reg.qid  <= queue_id;
            s1_req_reg.item <= item;
        end
        if (s2_free && s1_fire)
        begin
            s2_status_reg <= s2_status_next;
            s2_full_reg   <= s2_full_next;
            s2_rdsel_reg  <= s2_rdsel_next;
            s2_data_reg   <= s2_data_next;
        end
    end

    // ------------------------------------------------------------------
    // Slot link and slot value stores
    // ------------------------------------------------------------------
    mqsb_ram #(
        .WIDTH (SW),
        .DEPTH (NUM_SLOTS)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (link_re),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    mqsb_ram #(
        .WIDTH (mqsb_pkg::DATA_W),
        .DEPTH (NUM_SLOTS)
    ) u_value_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_wdata),
        .re    (val_re),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign out_valid  = s2_valid_reg;
    assign data       = s2_rdsel_reg ? $signed(val_rdata) : $signed(s2_data_reg);
    assign status     = s2_status_reg;
    assign store_full = s2_full_reg;

endmodule

`default_nettype wire

FILE: hdl/mqsb_ram.sv
// ----------------------------------------------------------------------------
// mqsb_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered, enabled read. A read of the address written in the same cycle
// returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module mqsb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic                                     re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds its data when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/mqsb_checker.sv
// ----------------------------------------------------------------------------
// mqsb_checker
// Port-level checks for the multi-queue shared buffer, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module mqsb_checker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    input  wire logic                               in_stall,
    input  wire logic                               opcode,
    input  wire logic [mqsb_pkg::QID_W-1:0]         queue_id,
    input  wire logic signed [mqsb_pkg::DATA_W-1:0] item,
    input  wire logic                               out_valid,
    input  wire logic                               out_stall,
    input  wire logic signed [mqsb_pkg::DATA_W-1:0] data,
    input  wire logic [1:0]                         status,
    input  wire logic                               store_full
);

    // Stalled request holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(opcode) && $stable(queue_id)
                                 && $stable(item))
        else $error("request changed while stalled");

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(data) && $stable(status)
                                   && $stable(store_full))
        else $error("result changed while stalled");

    // Input side only backs up when the output is stalled
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled without output stall");

    // Empty queue reads return the marker value
    a_underflow_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == mqsb_pkg::ST_UNDERFLOW |-> data == 32'sh7FFF_FFFF)
        else $error("underflow without marker value");

    // Refused enqueue returns zero
    a_overflow_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == mqsb_pkg::ST_OVERFLOW |-> data == '0)
        else $error("overflow with nonzero data");

endmodule

bind multi_queue_shared_buffer mqsb_checker u_mqsb_checker (.*);

`default_nettype wire

FILE: tb/sv/mqsb_queue_checker.sv
// ----------------------------------------------------------------------------
// mqsb_queue_checker
// Watches the request and result channels of the multi-queue shared buffer,
// tracks the linked slot store and free list on its own, and compares every
// result with the predicted one, oldest first.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module mqsb_queue_checker #(
    parameter int NUM_QUEUES = 4,
    parameter int NUM_SLOTS  = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // request channel
    input  wire logic                               in_valid,
    input  wire logic                               in_stall,
    input  wire logic                               opcode,
    input  wire logic [mqsb_pkg::QID_W-1:0]         queue_id,
    input  wire logic signed [mqsb_pkg::DATA_W-1:0] item,
    // result channel
    input  wire logic                               out_valid,
    input  wire logic                               out_stall,
    input  wire logic signed [mqsb_pkg::DATA_W-1:0] data,
    input  wire logic [1:0]                         status,
    input  wire logic                               store_full,
    // to the top
    output int                                      fail_count,
    output int                                      pending
);

    localparam int SLOT_W = $clog2(NUM_SLOTS);

    typedef struct {
        logic signed [mqsb_pkg::DATA_W-1:0] data;
        mqsb_pkg::status_t                  status;
        logic                               full;
    } queue_result_t;

    // Shadow of the slot store, per-queue pointers and free list
    logic signed [mqsb_pkg::DATA_W-1:0] slot_val  [NUM_SLOTS];
    logic [SLOT_W-1:0]                  slot_next [NUM_SLOTS];
    bit                                 next_ok   [NUM_SLOTS];
    logic [SLOT_W-1:0]                  head_slot [NUM_QUEUES];
    bit                                 head_ok   [NUM_QUEUES];
    logic [SLOT_W-1:0]                  tail_slot [NUM_QUEUES];
    logic [SLOT_W-1:0]                  free_slot;
    bit                                 free_ok;

    // Results predicted but not yet seen on the result channel
    queue_result_t results_due[$];

    // Apply one request to the shadow state and return what it should produce
    function automatic queue_result_t apply_queue_op(
        mqsb_pkg::op_t                      op,
        logic [mqsb_pkg::QID_W-1:0]         qid,
        logic signed [mqsb_pkg::DATA_W-1:0] val
    );
        queue_result_t     res;
        logic [SLOT_W-1:0] s;
        res.data   = '0;
        res.status = mqsb_pkg::ST_OK;
        if (op == mqsb_pkg::OP_ENQ)
        begin
            if (qid >= NUM_QUEUES || !free_ok)
            begin
                res.status = mqsb_pkg::ST_OVERFLOW;
            end
            else
            begin
                // pop the free list, link onto the queue tail
                s = free_slot;
                free_slot = slot_next[s];
                free_ok   = next_ok[s];
                if (!head_ok[qid])
                begin
                    head_slot[qid] = s;
                    head_ok[qid]   = 1'b1;
                end
                else
                begin
                    slot_next[tail_slot[qid]] = s;
                    next_ok[tail_slot[qid]]   = 1'b1;
                end
                slot_next[s]   = '0;
                next_ok[s]     = 1'b0;
                tail_slot[qid] = s;
                slot_val[s]    = val;
            end
        end
        else
        begin
            if (qid >= NUM_QUEUES || !head_ok[qid])
            begin
                res.status = mqsb_pkg::ST_UNDERFLOW;
                res.data   = mqsb_pkg::EMPTY_VALUE;
            end
            else
            begin
                // unlink the head, push it onto the front of the free list
                s = head_slot[qid];
                head_slot[qid] = slot_next[s];
                head_ok[qid]   = next_ok[s];
                slot_next[s]   = free_slot;
                next_ok[s]     = free_ok;
                free_slot      = s;
                free_ok        = 1'b1;
                res.data       = slot_val[s];
            end
        end
        res.full = !free_ok;
        return res;
    endfunction

    // Predict on accepted requests, compare on accepted results
    always @(posedge clk or negedge rst_n)
    begin
        queue_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_val[i]  = '0;
                slot_next[i] = SLOT_W'(i + 1);
                next_ok[i]   = (i + 1 < NUM_SLOTS);
            end
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                head_slot[i] = '0;
                head_ok[i]   = 1'b0;
                tail_slot[i] = '0;
            end
            free_slot = '0;
            free_ok   = 1'b1;
            results_due.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                results_due.insert(results_due.size(),
                                   apply_queue_op(mqsb_pkg::op_t'(opcode), queue_id, item));
            if (out_valid && !out_stall)
            begin
                if (results_due.size() == 0)
                begin
                    $error("result with no request outstanding: data %0d status %0d",
                           data, status);
                    fail_count++;
                end
                else
                begin
                    want = results_due.pop_front();
                    if (data !== want.data)
                    begin
                        $error("data: expected %0d, actual %0d", want.data, data);
                        fail_count++;
                    end
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, status);
                        fail_count++;
                    end
                    if (store_full !== want.full)
                    begin
                        $error("store_full: expected %0d, actual %0d", want.full,
                               store_full);
                        fail_count++;
                    end
                end
            end
            pending = results_due.size();
        end
    end

endmodule

FILE: tb/sv/tb_multi_queue_shared_buffer.sv
// ----------------------------------------------------------------------------
// tb_multi_queue_shared_buffer
// Drives enqueue and dequeue requests into the shared-buffer queue manager
// with random gaps and result-side stalls; a side checker predicts and
// compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_multi_queue_shared_buffer;

    localparam int NUM_QUEUES  = 4;
    localparam int NUM_SLOTS   = 16;
    localparam int RAND_REQS   = 1025;
    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_WAIT  = 8;

    logic                               clk        = 1'b0;
    logic                               rst_n      = 1'b0;
    logic                               in_valid   = 1'b0;
    logic                               in_stall;
    logic                               opcode     = 1'b0;
    logic [mqsb_pkg::QID_W-1:0]         queue_id   = '0;
    logic signed [mqsb_pkg::DATA_W-1:0] item       = '0;
    logic                               out_valid;
    logic                               out_stall  = 1'b0;
    logic signed [mqsb_pkg::DATA_W-1:0] data;
    logic [1:0]                         status;
    logic                               store_full;

    int fail_count;
    int pending;
    int idle_cycles = 0;
    int stall_left  = 0;
    bit calm        = 1'b0;

    multi_queue_shared_buffer #(
        .NUM_QUEUES (NUM_QUEUES),
        .NUM_SLOTS  (NUM_SLOTS)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .queue_id   (queue_id),
        .item       (item),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .data       (data),
        .status     (status),
        .store_full (store_full)
    );

    mqsb_queue_checker #(
        .NUM_QUEUES (NUM_QUEUES),
        .NUM_SLOTS  (NUM_SLOTS)
    ) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .queue_id   (queue_id),
        .item       (item),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .data       (data),
        .status     (status),
        .store_full (store_full),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    // Corner values of the 32-bit item
    function automatic logic signed [mqsb_pkg::DATA_W-1:0] corner_value(int k);
        case (k % 6)
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return 32'sh0000_0000;
            3:       return -32'sd1;
            4:       return 32'shAAAA_AAAA;
            default: return 32'sh5555_5555;
        endcase
    endfunction

    function automatic logic signed [mqsb_pkg::DATA_W-1:0] pick_value();
        if ($urandom_range(0, 7) == 0)
            return corner_value($urandom_range(0, 5));
        return $urandom;
    endfunction

    // Issue one request; called and returns at a falling edge
    task automatic push_request(mqsb_pkg::op_t op, logic [mqsb_pkg::QID_W-1:0] qid,
                                logic signed [mqsb_pkg::DATA_W-1:0] val);
        int n;
        n = pick_gap();
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        queue_id <= qid;
        item     <= val;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // Result-side backpressure in random bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            if (!calm && $urandom_range(0, 99) < 25)
                stall_left <= pick_gap() + 1;
        end
    end

    // Watchdog: cycles with no request and no result accepted
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Stimulus and verdict
    initial
    begin
        int                         sent;
        int                         run_len;
        int                         enq_pct;
        int                         hot_pct;
        logic [mqsb_pkg::QID_W-1:0] hot_q;
        logic [mqsb_pkg::QID_W-1:0] q;
        mqsb_pkg::op_t              op;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: underflow on every queue, fill the store, overflow, drain some
        for (int i = 0; i < NUM_QUEUES; i++)
            push_request(mqsb_pkg::OP_DEQ, i[mqsb_pkg::QID_W-1:0], $urandom);
        for (int i = 0; i < NUM_SLOTS; i++)
            push_request(mqsb_pkg::OP_ENQ, i[mqsb_pkg::QID_W-1:0],
                         (i < 6) ? corner_value(i) : pick_value());
        push_request(mqsb_pkg::OP_ENQ, 2'd2, 32'sh1234_5678);
        for (int i = 0; i < NUM_QUEUES; i++)
            push_request(mqsb_pkg::OP_DEQ, i[mqsb_pkg::QID_W-1:0], $urandom);

        // Random phases: varying enqueue bias, optional hot queue, some calm stretches
        sent = 0;
        while (sent < RAND_REQS)
        begin
            case ($urandom_range(0, 3))
                0:       enq_pct = 25;
                1:       enq_pct = 50;
                2:       enq_pct = 75;
                default: enq_pct = 92;
            endcase
            hot_pct = ($urandom_range(0, 2) == 0) ? 75 : 0;
            hot_q   = mqsb_pkg::QID_W'($urandom_range(0, NUM_QUEUES - 1));
            calm    = ($urandom_range(0, 3) == 0);
            run_len = $urandom_range(40, 120);
            for (int k = 0; k < run_len && sent < RAND_REQS; k++)
            begin
                q  = ($urandom_range(0, 99) < hot_pct)
                     ? hot_q : mqsb_pkg::QID_W'($urandom_range(0, NUM_QUEUES - 1));
                op = ($urandom_range(0, 99) < enq_pct) ? mqsb_pkg::OP_ENQ
                                                       : mqsb_pkg::OP_DEQ;
                push_request(op, q, pick_value());
                sent++;
            end
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        // Drain, then let the pipeline settle before the verdict
        wait (pending == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
